[rtl/double_ended_queue_top_macros.svh]
// ----------------------------------------------------------------------------
// double_ended_queue_top_macros.svh
// assertion macros used by the deque datapath; define NO_ASSERTIONS to drop them
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only while out of reset
`define DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked at every edge, reset included
`define DQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DQ_ASSERT(lbl, prop, msg)
`define DQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// types and codes shared by the deque controller, datapath and top level
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_TRAVERSE   = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_OUT,
    S_TRV_RD,
    S_TRV_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    push_front;
    logic    push_back;
    logic    pop_front;
    logic    pop_back;
    logic    trav_start;
    logic    trav_next;
    logic    load_resp;    // load output register with a status-only word
    logic    load_rdata;   // load output register from the memory read data
    logic    rd_last;      // last flag for load_rdata
    status_t resp_status;  // status for load_resp
  } dq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic trav_last;
  } dq_stat_t;

endpackage

`default_nettype wire

[rtl/dq_ctrl.sv]
// ----------------------------------------------------------------------------
// dq_ctrl
// operation decode and sequencing of push, pop and traverse
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [2:0]        in_op,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire dq_pkg::dq_stat_t  stat,
  output dq_pkg::dq_cmd_t        cmd
);

  import dq_pkg::*;

  state_t state_r;
  state_t state_nxt;
  op_t    op;

  assign op = op_t'(in_op);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: state_nxt = S_OUT;
            OP_POP_FRONT, OP_POP_BACK:   state_nxt = stat.empty ? S_OUT : S_POP_RD;
            OP_TRAVERSE:                 state_nxt = stat.empty ? S_OUT : S_TRV_RD;
            default:                     state_nxt = S_IDLE;
          endcase
        end
      end
      S_POP_RD:  state_nxt = S_OUT;
      S_OUT:     if (out_ready) state_nxt = S_IDLE;
      S_TRV_RD:  state_nxt = S_TRV_OUT;
      S_TRV_OUT: begin
        if (out_ready) state_nxt = stat.trav_last ? S_IDLE : S_TRV_RD;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              cmd.load_resp   = 1'b1;
              cmd.resp_status = stat.full ? STAT_FULL : STAT_OK;
              cmd.push_front  = !stat.full && (op == OP_PUSH_FRONT);
              cmd.push_back   = !stat.full && (op == OP_PUSH_BACK);
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              cmd.load_resp   = stat.empty;
              cmd.resp_status = STAT_EMPTY;
              cmd.pop_front   = !stat.empty && (op == OP_POP_FRONT);
              cmd.pop_back    = !stat.empty && (op == OP_POP_BACK);
            end
            OP_TRAVERSE: begin
              cmd.load_resp   = stat.empty;
              cmd.resp_status = STAT_EMPTY;
              cmd.trav_start  = !stat.empty;
            end
            default: ;
          endcase
        end
      end
      S_POP_RD: begin
        cmd.load_rdata = 1'b1;
        cmd.rd_last    = 1'b1;
      end
      S_OUT: begin
        out_valid = 1'b1;
      end
      S_TRV_RD: begin
        cmd.load_rdata = 1'b1;
        cmd.rd_last    = stat.trav_last;
      end
      S_TRV_OUT: begin
        out_valid     = 1'b1;
        cmd.trav_next = out_ready && !stat.trav_last;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/dq_datapath.sv]
// ----------------------------------------------------------------------------
// dq_datapath
// ring memory, front index, entry count, traverse index and output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_top_macros.svh"

module dq_datapath #(
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dq_pkg::dq_cmd_t            cmd,
  input  wire logic [dq_pkg::DATA_W-1:0]  in_value,
  output dq_pkg::dq_stat_t                stat,
  output logic [dq_pkg::DATA_W-1:0]       out_value,
  output logic [dq_pkg::STAT_W-1:0]       out_status,
  output logic                            out_last
);

  import dq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  trav_idx_r, trav_idx_nxt;

  logic [DATA_W-1:0] out_value_r;
  status_t           out_status_r;
  logic              out_last_r;

  logic [IDX_W-1:0]  front_dec, front_inc;
  logic [IDX_W-1:0]  back_wr_pos, back_rd_pos, trav_pos;
  logic [IDX_W-1:0]  waddr, raddr;
  logic              wr_en, rd_en, pop_en;

  // base stays below DEPTH and the used offsets at most DEPTH, so one compare and subtract wraps
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                               input logic [SUM_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + off;
    if (sum >= SUM_W'(DEPTH)) sum = sum - SUM_W'(DEPTH);
    return sum[IDX_W-1:0];
  endfunction

  assign front_dec   = ring_add(front_r, SUM_W'(DEPTH - 1));
  assign front_inc   = ring_add(front_r, SUM_W'(1));
  assign back_wr_pos = ring_add(front_r, SUM_W'(count_r));
  assign back_rd_pos = ring_add(front_r, SUM_W'(count_r) - SUM_W'(1));
  assign trav_pos    = ring_add(front_r, SUM_W'(trav_idx_r) + SUM_W'(1));

  assign stat.full      = (count_r == CNT_W'(DEPTH));
  assign stat.empty     = (count_r == '0);
  assign stat.trav_last = (SUM_W'(trav_idx_r) + SUM_W'(1) == SUM_W'(count_r));

  assign wr_en  = cmd.push_front || cmd.push_back;
  assign waddr  = cmd.push_front ? front_dec : back_wr_pos;
  assign pop_en = cmd.pop_front || cmd.pop_back;
  assign rd_en  = pop_en || cmd.trav_start || cmd.trav_next;

  always_comb begin
    if (cmd.pop_back) begin
      raddr = back_rd_pos;
    end else if (cmd.trav_next) begin
      raddr = trav_pos;
    end else begin
      raddr = front_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    front_nxt    = front_r;
    count_nxt    = count_r;
    trav_idx_nxt = trav_idx_r;
    if (cmd.push_front) begin
      front_nxt = front_dec;
    end else if (cmd.pop_front) begin
      front_nxt = front_inc;
    end
    if (wr_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.trav_start) begin
      trav_idx_nxt = '0;
    end else if (cmd.trav_next) begin
      trav_idx_nxt = trav_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r    <= '0;
      count_r    <= '0;
      trav_idx_r <= '0;
    end else begin
      front_r    <= front_nxt;
      count_r    <= count_nxt;
      trav_idx_r <= trav_idx_nxt;
    end
  end

  // output word register, held until the consumer takes it
  always_ff @(posedge clk) begin
    if (cmd.load_resp) begin
      out_value_r  <= '0;
      out_status_r <= cmd.resp_status;
      out_last_r   <= 1'b1;
    end else if (cmd.load_rdata) begin
      out_value_r  <= rdata_r;
      out_status_r <= STAT_OK;
      out_last_r   <= cmd.rd_last;
    end
  end

  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  `DQ_ASSERT_ALWAYS(a_count_bound, !rst_n || count_r <= CNT_W'(DEPTH), "entry count above depth")
  `DQ_ASSERT(a_push_not_full, wr_en |-> !stat.full, "push issued on a full queue")
  `DQ_ASSERT(a_read_not_empty, (pop_en || cmd.trav_start) |-> !stat.empty, "read on empty queue")
  `DQ_ASSERT(a_trav_in_range, cmd.trav_next |-> !stat.trav_last, "traverse stepped past the back")
  `DQ_ASSERT(a_pop_count, pop_en |=> count_r == $past(count_r) - CNT_W'(1), "pop missed count")

endmodule

`default_nettype wire

[rtl/double_ended_queue_top.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_top
// bounded double-ended queue of signed 32-bit words on stream channels
// ----------------------------------------------------------------------------
// Each input word carries an operation in in_tuser (0 push front, 1 push back,
// 2 pop front, 3 pop back, 4 traverse; other codes are dropped with no result)
// and a push value in in_tdata. Every operation but a dropped code returns
// result words: out_tdata holds the popped or traversed value (zero for push
// and error results), out_tuser the status (0 ok, 1 empty, 2 full, push
// dropped) and out_tlast marks the final result of the operation. A traverse
// returns every stored value from front to back and leaves the queue as is.
// The block works on one operation at a time and takes no new input word until
// the last result of the current one is taken; the consumer can hold off
// results by holding out_tready low. Pop and traverse values come through the
// registered read of the ring memory before they reach the output register.
// No clearing pass is needed after reset; the queue starts empty.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_top #(
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [dq_pkg::DATA_W-1:0]  in_tdata,   // value
  input  wire logic [dq_pkg::OP_W-1:0]    in_tuser,   // operation
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [dq_pkg::DATA_W-1:0]       out_tdata,  // item_value
  output logic [dq_pkg::STAT_W-1:0]       out_tuser,  // status
  output logic                            out_tlast
);

  import dq_pkg::*;

  dq_cmd_t  cmd;
  dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_value   (in_tdata),
    .stat       (stat),
    .out_value  (out_tdata),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire

[tb/sv/double_ended_queue_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb
// self-checking bench for the bounded double-ended queue on stream channels
// ----------------------------------------------------------------------------
// Operations go in through the input stream, with random bursts and gaps.
// The output side stalls on a random pattern, and once it holds off long
// enough to back up the input in the test that fills the queue. A shadow
// ring, front index and count track the queue. Each accepted operation adds
// its expected result words to a list, and every word taken from the output
// is checked against the oldest entry on that list.
// ----------------------------------------------------------------------------

module double_ended_queue_top_tb;
  import dq_pkg::*;

  localparam int DQ_DEPTH       = 16;
  localparam int IDX_W          = $clog2(DQ_DEPTH);
  localparam int CNT_W          = IDX_W + 1;
  localparam int RANDOM_ITEMS   = 360;
  localparam int PHASE_ITEMS    = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 2 * DQ_DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 5000;

  // operation codes the block drops without a result
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_W-1:0] OP_LAST_CODE    = 3'd7;

  typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_SPARSE} rdy_mode_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    status_t           status;
    logic              last;
  } result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata  = '0;   // value
  logic [OP_W-1:0]   in_tuser  = '0;   // operation
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;        // item_value
  logic [STAT_W-1:0] out_tuser;        // status
  logic              out_tlast;

  // shadow copy of the queue
  logic [DATA_W-1:0] shadow_ring [DQ_DEPTH];
  logic [IDX_W-1:0]  shadow_front = '0;
  logic [CNT_W-1:0]  shadow_count = '0;

  result_t   results_due[$];
  int        fail_count    = 0;
  int        burst_left    = 0;
  int        gap_max       = 0;
  rdy_mode_t rdy_mode      = RDY_ALWAYS;
  int        hold_requests = 0;
  int        holds_served  = 0;
  int        hold_left     = 0;
  int        quiet_cycles  = 0;

  always #10 clk = ~clk;

  double_ended_queue_top #(
    .DEPTH(DQ_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  task automatic add_result_due(input logic [DATA_W-1:0] value, input status_t status,
                                input logic last);
    result_t r;
    r.value  = value;
    r.status = status;
    r.last   = last;
    results_due.push_back(r);
  endtask

  // update the shadow queue for one accepted word and list its results
  task automatic apply_deque_op(input logic [OP_W-1:0] op_bits,
                                input logic [DATA_W-1:0] val);
    logic [IDX_W-1:0] pos;
    int               i;
    case (op_bits) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count >= CNT_W'(DQ_DEPTH)) begin
          add_result_due('0, STAT_FULL, 1'b1);
        end else begin
          if (op_bits == OP_PUSH_FRONT) begin
            shadow_front = shadow_front - IDX_W'(1);
            pos = shadow_front;
          end else begin
            pos = shadow_front + IDX_W'(shadow_count);
          end
          shadow_ring[pos] = val;
          shadow_count = shadow_count + CNT_W'(1);
          add_result_due('0, STAT_OK, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_count == '0) begin
          add_result_due('0, STAT_EMPTY, 1'b1);
        end else begin
          if (op_bits == OP_POP_FRONT) begin
            pos = shadow_front;
            shadow_front = shadow_front + IDX_W'(1);
          end else begin
            pos = shadow_front + IDX_W'(shadow_count - CNT_W'(1));
          end
          add_result_due(shadow_ring[pos], STAT_OK, 1'b1);
          shadow_count = shadow_count - CNT_W'(1);
        end
      end
      OP_TRAVERSE: begin
        if (shadow_count == '0) begin
          add_result_due('0, STAT_EMPTY, 1'b1);
        end else begin
          for (i = 0; i < int'(shadow_count); i++) begin
            pos = shadow_front + IDX_W'(i);
            add_result_due(shadow_ring[pos], STAT_OK, i == int'(shadow_count) - 1);
          end
        end
      end
      default: ;
    endcase
  endtask

  // offer one word; valid stays high inside a burst
  task automatic send_word(input logic [OP_W-1:0] op_bits, input logic [DATA_W-1:0] val);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser  = op_bits;
    in_tdata  = val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_deque_op(op_bits, val);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)
      return OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
    else if (r < 13)
      return OP_TRAVERSE;
    else if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    else
      return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
  endfunction

  // receiver: long hold-offs on request, otherwise its own random stalls
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      case (rdy_mode)
        RDY_ALWAYS: out_tready = 1'b1;
        RDY_MOSTLY: out_tready = $urandom_range(0, 3) != 0;
        default:    out_tready = $urandom_range(0, 3) == 0;
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result word value %h status %0d last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        if (out_tdata !== want.value) begin
          $display("%0t: item_value expected %h actual %h", $time, want.value, out_tdata);
          fail_count++;
        end
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_empty_queue();
    send_word(OP_POP_FRONT, pick_value());
    send_word(OP_POP_BACK, pick_value());
    send_word(OP_TRAVERSE, pick_value());
  endtask

  task automatic test_extreme_values();
    send_word(OP_PUSH_FRONT, 32'h8000_0000);
    send_word(OP_PUSH_BACK, 32'h7fff_ffff);
    send_word(OP_PUSH_FRONT, 32'hffff_ffff);
    send_word(OP_TRAVERSE, '0);
    send_word(OP_POP_BACK, '0);
    send_word(OP_POP_FRONT, '1);
    // front pop of the only entry
    send_word(OP_POP_FRONT, '0);
    send_word(OP_PUSH_BACK, '0);
    // back pop of the only entry must leave the queue empty
    send_word(OP_POP_BACK, '1);
    send_word(OP_TRAVERSE, '0);
  endtask

  task automatic test_unused_codes();
    logic [OP_W-1:0] op;
    send_word(OP_PUSH_BACK, pick_value());
    for (op = OP_FIRST_UNUSED; op != '0; op++)
      send_word(op, pick_value());
    send_word(OP_TRAVERSE, pick_value());
    send_word(OP_POP_FRONT, pick_value());
  endtask

  task automatic test_full_queue_backpressure();
    int i;
    gap_max    = 0;
    burst_left = 0;
    rdy_mode   = RDY_ALWAYS;
    hold_requests++;
    // alternate ends so the front index wraps
    for (i = 0; i < DQ_DEPTH; i++)
      send_word((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
    send_word(OP_PUSH_FRONT, pick_value());
    send_word(OP_PUSH_BACK, pick_value());
    send_word(OP_TRAVERSE, pick_value());
  endtask

  task automatic test_random_ops();
    int              counted;
    int              push_pct;
    logic [OP_W-1:0] op;
    counted  = 0;
    push_pct = 25;
    while (counted < RANDOM_ITEMS) begin
      if (counted % PHASE_ITEMS == 0) begin
        push_pct = (push_pct < 50) ? 75 : 25;
        case ($urandom_range(0, 2))
          0:       gap_max = 0;
          1:       gap_max = 3;
          default: gap_max = 8;
        endcase
        rdy_mode = rdy_mode_t'($urandom_range(0, 2));
      end
      op = pick_op(push_pct);
      send_word(op, pick_value());
      if (op <= OP_TRAVERSE)
        counted++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    gap_max  = 2;
    rdy_mode = RDY_MOSTLY;
    test_empty_queue();
    test_extreme_values();
    test_unused_codes();
    test_full_queue_backpressure();
    test_random_ops();

    @(negedge clk);
    in_tvalid = 1'b0;
    rdy_mode  = RDY_MOSTLY;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
